@@ hdl/assert_macros.svh @@
// Assertion macros shared by the executor RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SIE_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SIE_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/sie_pkg.sv @@
// Types and opcodes for the sparse instruction executor.
// No dependencies; imported by the register file, the top level and the testbench.
package sie_pkg;

  typedef enum logic [4:0] {
    K_ZMUL  = 5'd0,
    K_ADD   = 5'd1,
    K_ADDI  = 5'd2,
    K_SLT   = 5'd3,
    K_SLTI  = 5'd4,
    K_SUB   = 5'd5,
    K_MOV   = 5'd6,
    K_LW    = 5'd7,
    K_LNZ   = 5'd8,
    K_SW    = 5'd9,
    K_VLOAD = 5'd10,
    K_BEQ   = 5'd11,
    K_BNE   = 5'd12,
    K_BZERO = 5'd13,
    K_JMP   = 5'd14,
    K_JR    = 5'd15,
    K_HALT  = 5'd16
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_MEM,
    ST_PTR,
    ST_VLD
  } state_e;

  localparam int unsigned VecLen   = 4;
  localparam int unsigned VecWords = 128;

  typedef struct packed {
    logic [4:0]         kind;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
  } in_t;

  typedef struct packed {
    logic [9:0]         next_pc;
    logic               reg_written;
    logic [4:0]         written_reg;
    logic signed [31:0] written_value;
    logic               pointer_updated;
    logic [9:0]         pointer_value;
    logic               halted;
    logic               scan_fault;
  } out_t;

endpackage

@@ hdl/sie_regfile.sv @@
// Scalar register file: two registered read ports, one write port.
// Depends on sie_pkg; register 0 and unwritten entries read as zero.
module sie_regfile #(
  parameter int unsigned NUM_REGS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        re_i,
  input  logic [4:0]  ra_a_i,
  input  logic [4:0]  ra_b_i,
  input  logic        we_i,
  input  logic [4:0]  wa_i,
  input  logic [31:0] wd_i,
  output logic [31:0] rd_a_o,
  output logic [31:0] rd_b_o
);
  import sie_pkg::*;

  localparam int unsigned RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;
  logic [31:0]         da_q, db_q;
  logic                oka_q, okb_q;
  logic                ok_a, ok_b, ok_w;

  assign ok_a = (ra_a_i != 5'd0) && ({1'b0, ra_a_i} < 6'(NUM_REGS));
  assign ok_b = (ra_b_i != 5'd0) && ({1'b0, ra_b_i} < 6'(NUM_REGS));
  assign ok_w = we_i && (wa_i != 5'd0) && ({1'b0, wa_i} < 6'(NUM_REGS));

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (ok_w) begin
      mem[wa_i[RW-1:0]] <= wd_i;
    end
    if (re_i) begin
      da_q <= mem[ra_a_i[RW-1:0]];
      db_q <= mem[ra_b_i[RW-1:0]];
    end
  end

  // Track written entries; register the read masks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      oka_q <= 1'b0;
      okb_q <= 1'b0;
    end else begin
      if (ok_w) begin
        vld_q[wa_i[RW-1:0]] <= 1'b1;
      end
      if (re_i) begin
        oka_q <= ok_a && vld_q[ra_a_i[RW-1:0]];
        okb_q <= ok_b && vld_q[ra_b_i[RW-1:0]];
      end
    end
  end

  assign rd_a_o = oka_q ? da_q : 32'd0;
  assign rd_b_o = okb_q ? db_q : 32'd0;

endmodule

@@ hdl/sparse_isa_instruction_executor_core.sv @@
// Top level of the sparse instruction executor: sequencer, data and vector memories.
// Depends on sie_pkg, sie_regfile and assert_macros.svh.
//
// One instruction is taken per start transfer while busy is low, and its result is
// shown for one cycle with valid_o, registered, so the next instruction can be taken
// in the cycle the result appears. ALU, move, store, branch, jump and halt read the
// register file, then execute and write back; zmul writes back from the product
// register; lw and lnz write back from the data memory read port; lnz reads upward one
// word at a time past zero words, and advances its base register in a separate state
// (single register-file write port); vload makes four data memory reads. After
// reset the data memory is cleared one word a cycle, with busy high.
// Data and program sizes must be powers of two; the block does not check this.
`include "assert_macros.svh"
module sparse_isa_instruction_executor_core #(
  parameter int unsigned NUM_REGS   = 32,
  parameter int unsigned DATA_WORDS = 1024,
  parameter int unsigned PROG_WORDS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sie_pkg::in_t  instr_i,
  output logic          valid_o,
  output sie_pkg::out_t result_o
);
  import sie_pkg::*;

  localparam int unsigned AW = $clog2(DATA_WORDS);
  localparam int unsigned PW = $clog2(PROG_WORDS);

  state_e      st_q, st_d;
  in_t         ins_q;
  logic [PW-1:0] pc_q, pc_d, npc, pc_inc, target;
  logic        halted_q, halted_d;
  logic [AW-1:0] scan_q, scan_d, clr_q, clr_d;
  logic [1:0]  vcnt_q, vcnt_d;
  logic [31:0] mul_q, mul_d;
  out_t        res_q, res_d;
  logic        valid_q, emit;
  logic        accept;

  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd, rf_a, rf_b;

  logic [31:0] dmem [DATA_WORDS];
  logic [31:0] dm_q, dm_wd;
  logic        dm_we, dm_re;
  logic [AW-1:0] dm_wa, dm_ra;

  logic [31:0] vmem [VecWords];
  logic        vr_we;
  logic [6:0]  vr_wa;

  logic        wen, rep, fault;
  logic [31:0] wv, sum, pval, npc_w;
  logic        dest_ok, ptr_ok;

  assign accept = start && !busy;
  assign busy   = (st_q != ST_IDLE);

  sie_regfile #(.NUM_REGS(NUM_REGS)) u_rf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .re_i   (accept),
    .ra_a_i (instr_i.src1_reg),
    .ra_b_i (instr_i.src2_reg),
    .we_i   (rf_we),
    .wa_i   (rf_wa),
    .wd_i   (rf_wd),
    .rd_a_o (rf_a),
    .rd_b_o (rf_b)
  );

  assign pc_inc  = pc_q + 1'b1;
  assign target  = pc_q + ins_q.immediate[PW-1:0];
  assign sum     = rf_a + ins_q.immediate;
  assign pval    = 32'(scan_q) + 32'd1;
  assign dest_ok = (ins_q.dest_reg != 5'd0) && ({1'b0, ins_q.dest_reg} < 6'(NUM_REGS));
  assign ptr_ok  = (ins_q.src1_reg != ins_q.dest_reg) && (ins_q.src1_reg != 5'd0)
                   && ({1'b0, ins_q.src1_reg} < 6'(NUM_REGS));
  assign npc_w   = 32'(npc);

  // Sequence one instruction: next state, memory accesses and result
  always_comb begin
    st_d     = st_q;
    pc_d     = pc_q;
    halted_d = halted_q;
    scan_d   = scan_q;
    clr_d    = clr_q;
    vcnt_d   = vcnt_q;
    mul_d    = mul_q;
    npc      = pc_inc;
    emit     = 1'b0;
    wen      = 1'b0;
    rep      = 1'b0;
    fault    = 1'b0;
    wv       = 32'd0;
    rf_we    = 1'b0;
    rf_wa    = ins_q.dest_reg;
    rf_wd    = 32'd0;
    dm_we    = 1'b0;
    dm_wa    = sum[AW-1:0];
    dm_wd    = rf_b;
    dm_re    = 1'b0;
    dm_ra    = sum[AW-1:0];
    vr_we    = 1'b0;
    vr_wa    = {ins_q.dest_reg, vcnt_q};
    res_d    = '0;

    case (st_q)
      ST_CLEAR: begin
        dm_we = 1'b0;
        if (clr_q == AW'(DATA_WORDS - 1)) begin
          st_d = ST_IDLE;
        end
        clr_d = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          st_d = ST_READ;
        end
      end
      ST_READ: begin
        if (halted_q) begin
          npc  = pc_q;
          emit = 1'b1;
        end else begin
          case (kind_e'(ins_q.kind))
            K_ZMUL: begin
              mul_d = rf_a * rf_b;
              st_d  = ST_MUL;
            end
            K_ADD:  begin wen = 1'b1; wv = rf_a + rf_b; emit = 1'b1; end
            K_ADDI: begin wen = 1'b1; wv = sum; emit = 1'b1; end
            K_SLT: begin
              wen  = 1'b1;
              wv   = {31'd0, $signed(rf_a) < $signed(rf_b)};
              emit = 1'b1;
            end
            K_SLTI: begin
              wen  = 1'b1;
              wv   = {31'd0, $signed(rf_a) < ins_q.immediate};
              emit = 1'b1;
            end
            K_SUB:  begin wen = 1'b1; wv = rf_a - rf_b; emit = 1'b1; end
            K_MOV:  begin wen = 1'b1; wv = ins_q.immediate; emit = 1'b1; end
            K_LW, K_LNZ: begin
              dm_re  = 1'b1;
              scan_d = sum[AW-1:0];
              st_d   = ST_MEM;
            end
            K_VLOAD: begin
              dm_re  = 1'b1;
              scan_d = sum[AW-1:0];
              vcnt_d = 2'd0;
              st_d   = ST_VLD;
            end
            K_SW: begin
              dm_we = 1'b1;
              emit  = 1'b1;
            end
            K_BEQ:   begin if (rf_a == rf_b) npc = target; emit = 1'b1; end
            K_BNE:   begin if (rf_a != rf_b) npc = target; emit = 1'b1; end
            K_BZERO: begin if (rf_a == 32'd0) npc = target; emit = 1'b1; end
            K_JMP:   begin npc = target; emit = 1'b1; end
            K_JR:    begin npc = rf_a[PW-1:0]; emit = 1'b1; end
            K_HALT: begin
              halted_d = 1'b1;
              npc      = pc_q;
              emit     = 1'b1;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      ST_MUL: begin
        wen  = 1'b1;
        wv   = mul_q;
        emit = 1'b1;
      end
      ST_MEM: begin
        if (kind_e'(ins_q.kind) == K_LW) begin
          wen  = 1'b1;
          wv   = dm_q;
          emit = 1'b1;
        end else if (dm_q != 32'd0) begin
          wen = 1'b1;
          wv  = dm_q;
          if (ptr_ok) begin
            st_d = ST_PTR;
          end else begin
            emit = 1'b1;
          end
        end else if (scan_q == AW'(DATA_WORDS - 1)) begin
          fault = 1'b1;
          emit  = 1'b1;
        end else begin
          scan_d = scan_q + 1'b1;
          dm_re  = 1'b1;
          dm_ra  = scan_d;
        end
      end
      ST_PTR: begin
        // Advance the base register; report the load done last cycle
        rep   = 1'b1;
        wv    = dm_q;
        rf_we = 1'b1;
        rf_wa = ins_q.src1_reg;
        rf_wd = pval;
        res_d.pointer_updated = 1'b1;
        res_d.pointer_value   = pval[9:0];
        emit  = 1'b1;
      end
      ST_VLD: begin
        vr_we = 1'b1;
        if (vcnt_q == 2'(VecLen - 1)) begin
          emit = 1'b1;
        end else begin
          vcnt_d = vcnt_q + 1'b1;
          dm_re  = 1'b1;
          dm_ra  = scan_q + AW'(vcnt_q) + 1'b1;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    // Write back the destination
    if (wen) begin
      rf_we = 1'b1;
      rf_wd = wv;
      if (st_q != ST_PTR && !(st_q == ST_MEM && kind_e'(ins_q.kind) == K_LNZ && ptr_ok
                              && !fault)) begin
        rep = 1'b1;
      end
    end
    if (rep && dest_ok) begin
      res_d.reg_written   = 1'b1;
      res_d.written_reg   = ins_q.dest_reg;
      res_d.written_value = wv;
    end
    if (emit) begin
      st_d = ST_IDLE;
      pc_d = npc;
    end
    res_d.next_pc    = npc_w[9:0];
    res_d.halted     = halted_d;
    res_d.scan_fault = fault;
  end

  // Data memory: clear sweep, store, and one registered read
  always_ff @(posedge clk_i) begin
    if (st_q == ST_CLEAR) begin
      dmem[clr_q] <= 32'd0;
    end else if (dm_we) begin
      dmem[dm_wa] <= dm_wd;
    end
    if (dm_re) begin
      dm_q <= dmem[dm_ra];
    end
  end

  // Vector register memory
  always_ff @(posedge clk_i) begin
    if (vr_we) begin
      vmem[vr_wa] <= dm_q;
    end
  end

  // Hold the instruction, the product and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ins_q <= instr_i;
    end
    mul_q <= mul_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_CLEAR;
      pc_q     <= '0;
      halted_q <= 1'b0;
      scan_q   <= '0;
      clr_q    <= '0;
      vcnt_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      pc_q     <= pc_d;
      halted_q <= halted_d;
      scan_q   <= scan_d;
      clr_q    <= clr_d;
      vcnt_q   <= vcnt_d;
      valid_q  <= emit;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

  `SIE_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> busy, "accepted item not in progress")
  `SIE_ASSERT(a_one_result, clk_i, rst_ni, valid_o |=> !valid_o, "result strobe held twice")
  `SIE_ASSERT(a_halt_sticky, clk_i, rst_ni, halted_q |=> halted_q, "halt flag dropped")
  `SIE_ASSERT(a_fault_nowrite, clk_i, rst_ni, valid_o && result_o.scan_fault |->
              !result_o.reg_written && !result_o.pointer_updated, "faulted scan wrote")

endmodule

@@ tb/sie_result_checker.sv @@
// Result checker for the sparse instruction executor: watches the instruction and
// result transfers, predicts every result and compares it field by field.
// Depends on sie_pkg.
`timescale 1ns / 100ps
module sie_result_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  sie_pkg::in_t  instr_i,
  input  logic          valid_i,
  input  sie_pkg::out_t result_i,
  output int            fail_cnt_o,
  output int            pending_o
);
  import sie_pkg::*;

  localparam int unsigned DataWords = 1024;

  // Architectural copy of the machine; vector registers are never visible, so skip them
  logic [9:0]  pc_q;
  logic [31:0] gpr_q [32];
  logic [31:0] dmem_q [DataWords];
  logic        halt_q;
  out_t        expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic [31:0] read_gpr(logic [4:0] r);
    return (r == 5'd0) ? 32'd0 : gpr_q[r];
  endfunction

  // Execute one instruction on the copy and return its result
  task automatic execute_instr(input in_t it, output out_t res);
    logic [31:0] a, b, imm, wval, scan_next;
    logic [9:0]  nxt, addr, target;
    logic        wen, pupd, fault;
    a         = read_gpr(it.src1_reg);
    b         = read_gpr(it.src2_reg);
    imm       = it.immediate;
    addr      = 10'(a + imm);
    target    = 10'(32'(pc_q) + imm);
    nxt       = pc_q + 10'd1;
    wval      = '0;
    wen       = 1'b0;
    pupd      = 1'b0;
    fault     = 1'b0;
    scan_next = '0;
    res       = '0;
    if (halt_q) begin
      nxt = pc_q;
    end else begin
      case (kind_e'(it.kind))
        K_ZMUL:  begin wval = (a == 0 || b == 0) ? 32'd0 : a * b; wen = 1'b1; end
        K_ADD:   begin wval = a + b; wen = 1'b1; end
        K_ADDI:  begin wval = a + imm; wen = 1'b1; end
        K_SLT:   begin wval = {31'd0, $signed(a) < $signed(b)}; wen = 1'b1; end
        K_SLTI:  begin wval = {31'd0, $signed(a) < $signed(imm)}; wen = 1'b1; end
        K_SUB:   begin wval = a - b; wen = 1'b1; end
        K_MOV:   begin wval = imm; wen = 1'b1; end
        K_LW:    begin wval = dmem_q[addr]; wen = 1'b1; end
        K_LNZ: begin
          // Scan upward past zero words, stop at the last word without wrapping
          while (addr != 10'(DataWords - 1) && dmem_q[addr] == 0) addr++;
          if (dmem_q[addr] == 0) begin
            fault = 1'b1;
          end else begin
            wval      = dmem_q[addr];
            wen       = 1'b1;
            scan_next = 32'(addr) + 32'd1;
            if (it.src1_reg != it.dest_reg && it.src1_reg != 5'd0) begin
              gpr_q[it.src1_reg] = scan_next;
              pupd = 1'b1;
            end
          end
        end
        K_SW:    dmem_q[addr] = b;
        K_VLOAD: ;
        K_BEQ:   if (a == b) nxt = target;
        K_BNE:   if (a != b) nxt = target;
        K_BZERO: if (a == 0) nxt = target;
        K_JMP:   nxt = target;
        K_JR:    nxt = a[9:0];
        K_HALT:  begin halt_q = 1'b1; nxt = pc_q; end
        default: ;
      endcase
      if (wen && it.dest_reg != 5'd0) begin
        gpr_q[it.dest_reg] = wval;
        res.reg_written    = 1'b1;
        res.written_reg    = it.dest_reg;
        res.written_value  = wval;
      end
      pc_q = nxt;
    end
    res.next_pc         = nxt;
    res.pointer_updated = pupd;
    res.pointer_value   = pupd ? scan_next[9:0] : 10'd0;
    res.halted          = halt_q;
    res.scan_fault      = fault;
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_cnt_o++;
    end
  endfunction

  // Compare results first, then predict the instruction taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_t res, exp_r;
    if (!rst_ni) begin
      pc_q   = '0;
      halt_q = 1'b0;
      foreach (gpr_q[i]) gpr_q[i] = '0;
      foreach (dmem_q[i]) dmem_q[i] = '0;
      expected_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (valid_i) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no instruction outstanding");
          fail_cnt_o++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("next_pc", 32'(exp_r.next_pc), 32'(result_i.next_pc));
          check_field("reg_written", 32'(exp_r.reg_written), 32'(result_i.reg_written));
          check_field("written_reg", 32'(exp_r.written_reg), 32'(result_i.written_reg));
          check_field("written_value", exp_r.written_value, result_i.written_value);
          check_field("pointer_updated", 32'(exp_r.pointer_updated),
                      32'(result_i.pointer_updated));
          check_field("pointer_value", 32'(exp_r.pointer_value),
                      32'(result_i.pointer_value));
          check_field("halted", 32'(exp_r.halted), 32'(result_i.halted));
          check_field("scan_fault", 32'(exp_r.scan_fault), 32'(result_i.scan_fault));
        end
      end
      if (start_i && !busy_i) begin
        execute_instr(instr_i, res);
        expected_q = {expected_q, res};
      end
    end
  end

endmodule

@@ tb/sparse_isa_instruction_executor_core_tb.sv @@
// Top of the executor testbench: clock, reset, directed and random instruction
// stimulus, watchdog and verdict. Depends on sie_pkg, the core and sie_result_checker.
`timescale 1ns / 100ps
module sparse_isa_instruction_executor_core_tb;
  import sie_pkg::*;

  localparam int StallLimit = 6000;  // memory clear or a full lnz scan plus margin

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  instr_i;
  logic valid_o;
  out_t result_o;
  int   fail_cnt;
  int   pending;
  int   idle_pct;
  int   stall_cycles;

  sparse_isa_instruction_executor_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .instr_i (instr_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  sie_result_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_i    (busy),
    .instr_i   (instr_i),
    .valid_i   (valid_o),
    .result_i  (result_o),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // End the run when no instruction transfer happens for too long
  always @(posedge clk_i) begin
    if (start && !busy) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("sparse_isa_instruction_executor_core_tb failed");
        $finish;
      end
    end
  end

  function automatic in_t make_instr(kind_e k, int rd, int rs1, int rs2, logic [31:0] imm);
    in_t it;
    it.kind      = k;
    it.dest_reg  = 5'(rd);
    it.src1_reg  = 5'(rs1);
    it.src2_reg  = 5'(rs2);
    it.immediate = imm;
    return it;
  endfunction

  // Hold start low for random gaps, then present the instruction until taken
  task automatic issue(input in_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start   <= 1'b1;
    instr_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Favor a few low registers so that results feed later instructions
  function automatic int pick_reg();
    return ($urandom_range(1) == 0) ? $urandom_range(7) : $urandom_range(31);
  endfunction

  function automatic in_t random_instr();
    in_t         it;
    int          sel;
    logic [31:0] imm;
    sel = $urandom_range(99);
    case ($urandom_range(9))
      0, 1:    imm = $urandom();
      2:       imm = $urandom_range(1023, 990);
      default: imm = 32'($signed($urandom_range(48)) - 8);
    endcase
    it = make_instr(K_ADD, pick_reg(), pick_reg(), pick_reg(), imm);
    if (sel < 15) begin
      it.kind = K_MOV;
      if ($urandom_range(1) == 0) it.immediate = $urandom_range(63);
    end else if (sel < 30) begin
      it.kind = K_SW;
    end else if (sel < 38) begin
      it.kind = K_LW;
    end else if (sel < 48) begin
      it.kind = K_LNZ;
    end else if (sel < 52) begin
      it.kind = K_VLOAD;
    end else if (sel < 72) begin
      it.kind = kind_e'($urandom_range(K_SUB, K_ZMUL));
    end else if (sel < 96) begin
      it.kind = kind_e'($urandom_range(K_JR, K_BEQ));
    end else begin
      it.kind = 5'($urandom_range(31, 17));
    end
    return it;
  endfunction

  initial begin
    in_t dir [$];
    stall_cycles = 0;
    idle_pct     = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    instr_i      = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every operation but halt, register zero, lnz corner cases
    dir = {dir, make_instr(K_MOV, 1, 0, 0, 32'h7fff_ffff)};
    dir = {dir, make_instr(K_MOV, 2, 0, 0, 32'h8000_0000)};
    dir = {dir, make_instr(K_MOV, 3, 31, 31, 32'hffff_ffff)};
    dir = {dir, make_instr(K_MOV, 0, 0, 0, 32'd55)};
    dir = {dir, make_instr(K_ADD, 4, 1, 3, 32'd0)};
    dir = {dir, make_instr(K_SUB, 5, 2, 3, 32'd0)};
    dir = {dir, make_instr(K_ADDI, 31, 1, 0, 32'd1)};
    dir = {dir, make_instr(K_SLT, 6, 2, 1, 32'd0)};
    dir = {dir, make_instr(K_SLTI, 7, 1, 0, 32'h8000_0000)};
    dir = {dir, make_instr(K_ZMUL, 8, 1, 3, 32'd0)};
    dir = {dir, make_instr(K_ZMUL, 9, 1, 0, 32'd0)};
    dir = {dir, make_instr(K_SW, 0, 0, 3, 32'd5)};
    dir = {dir, make_instr(K_SW, 0, 3, 1, 32'd0)};
    dir = {dir, make_instr(K_LW, 10, 0, 0, 32'd5)};
    dir = {dir, make_instr(K_LNZ, 11, 12, 0, 32'd0)};
    dir = {dir, make_instr(K_LNZ, 12, 12, 0, 32'd0)};
    dir = {dir, make_instr(K_LNZ, 13, 0, 0, 32'd900)};
    dir = {dir, make_instr(K_LNZ, 14, 15, 0, 32'd1023)};
    dir = {dir, make_instr(K_VLOAD, 31, 0, 0, 32'd1022)};
    dir = {dir, make_instr(K_BEQ, 0, 0, 0, 32'd7)};
    dir = {dir, make_instr(K_BNE, 0, 1, 2, 32'hffff_fffd)};
    dir = {dir, make_instr(K_BZERO, 0, 3, 0, 32'd4)};
    dir = {dir, make_instr(K_JMP, 0, 0, 0, 32'h8000_0000)};
    dir = {dir, make_instr(K_JR, 0, 3, 0, 32'd0)};
    dir = {dir, make_instr(kind_e'(5'd31), 31, 31, 31, 32'hffff_ffff)};
    foreach (dir[i]) issue(dir[i]);

    // Random: rotate through idle phases, pause once for a full drain
    for (int n = 0; n < 1200; n++) begin
      case ((n / 200) % 3)
        0: idle_pct = 0;
        1: idle_pct = 55;
        default: idle_pct = 12;
      endcase
      if (n == 600) drain();
      issue(random_instr());
    end

    // Halt last, then show that later instructions are ignored
    idle_pct = 12;
    issue(make_instr(K_HALT, 0, 0, 0, 32'd0));
    for (int n = 0; n < 4; n++) issue(random_instr());

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("sparse_isa_instruction_executor_core_tb passed");
    end else begin
      $display("sparse_isa_instruction_executor_core_tb failed");
    end
    $finish;
  end

endmodule
